FILE: rtl/otus_pkg.sv
//------------------------------------------------------------------------------
// otus_pkg: shared types and constants of the temporal unit splitter
// Error codes, parse phases, the result record and the fixed field widths.
//------------------------------------------------------------------------------
`default_nettype none

package otus_pkg;

	// default parameter values
	localparam int MAX_SIZE_BYTES_DEF = 8;
	localparam int LENGTH_BITS_DEF    = 32;

	// fixed field widths
	localparam int BYTE_BITS     = 8;
	localparam int SLOT_BITS     = 7;   // payload bits per LEB128 byte
	localparam int TYPE_BITS     = 5;
	localparam int TYPE_LSB      = 2;
	localparam int ACC_BITS      = 32;
	localparam int ERR_BITS      = 3;
	localparam int ERR_LSB       = ACC_BITS;
	localparam int OUT_DATA_BITS = 40;  // unit_length, error_code, zero pad
	localparam int HEADER_BYTES  = 2;

	localparam logic [TYPE_BITS-1:0] DELIM_RESET = TYPE_BITS'(2);

	typedef enum logic [ERR_BITS-1:0] {
		ERR_NONE       = 3'd0,
		ERR_FIELD_LONG = 3'd1,
		ERR_SIZE_WIDE  = 3'd2,
		ERR_SIZE_SMALL = 3'd3,
		ERR_TRUNCATED  = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		PH_SIZE = 2'd0,
		PH_HDR  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef struct packed {
		logic                emit;
		logic [ACC_BITS-1:0] len;
		err_t                err;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/obu_temporal_unit_splitter.sv
//------------------------------------------------------------------------------
// obu_temporal_unit_splitter: temporal unit lengths from a size-prefixed OBU stream
// Registers each stream word, parses it in one pass and registers the result.
//------------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  tdata: byte_value; tuser: action
//  m_*       out  m_tvalid / m_tready  tdata: unit_length, error_code
//  cfg_*     in   cfg_valid/cfg_ready  cfg_data: delimiter_type_code
//
//  One word per cycle while the input stage is not stalled: a word is
//  registered in the input stage, where the parser updates its state, and
//  a result lands in the output register, from which it can be taken.
//  Reset clears the parse state and loads delimiter type 2; no clearing pass.
//  A stall holds the input stage only when it would emit while the output
//  register is full and not taken; words with no result keep flowing.
//
`default_nettype none

module obu_temporal_unit_splitter
	import otus_pkg::*;
#(
	parameter int MAX_SIZE_BYTES = MAX_SIZE_BYTES_DEF,
	parameter int LENGTH_BITS    = LENGTH_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output      logic                     s_tready,
	input  wire logic [BYTE_BITS-1:0]     s_tdata,   // [7:0] byte_value
	input  wire logic                     s_tuser,   // [0] action: 1 = end of stream
	output      logic                     m_tvalid,
	input  wire logic                     m_tready,
	output      logic [OUT_DATA_BITS-1:0] m_tdata,   // [31:0] unit_length, [34:32] error_code
	input  wire logic                     cfg_valid,
	output      logic                     cfg_ready,
	input  wire logic [TYPE_BITS-1:0]     cfg_data   // [4:0] delimiter_type_code
);

	logic                 valid_s1;
	logic                 action_s1;
	logic [BYTE_BITS-1:0] byte_s1;
	logic [TYPE_BITS-1:0] delim_q;
	logic                 out_valid_q;
	logic [ACC_BITS-1:0]  len_q;
	err_t                 err_q;
	res_t                 res;
	logic                 advance;

	// advance the input stage unless its result has nowhere to go
	assign advance   = valid_s1 && (!out_valid_q || m_tready || !res.emit);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (cfg_valid) begin
			delim_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser;
			byte_s1   <= s_tdata;
		end
	end

	otus_parser #(
		.MAX_SIZE_BYTES(MAX_SIZE_BYTES),
		.LENGTH_BITS   (LENGTH_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.action    (action_s1),
		.byte_value(byte_s1),
		.delim     (delim_q),
		.res       (res)
	);

	// load the output register on an emitting word, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			len_q <= res.len;
			err_q <= res.err;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_BITS - ACC_BITS - ERR_BITS)'(0), err_q, len_q};

endmodule

`default_nettype wire

FILE: rtl/otus_parser.sv
//------------------------------------------------------------------------------
// otus_parser: size field decode and unit length bookkeeping
// Holds the parse state; gives the result of the presented word at once and
// commits the state update when step is high.
//------------------------------------------------------------------------------
`default_nettype none

module otus_parser
	import otus_pkg::*;
#(
	parameter int MAX_SIZE_BYTES = MAX_SIZE_BYTES_DEF,
	parameter int LENGTH_BITS    = LENGTH_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic                 action,
	input  wire logic [BYTE_BITS-1:0] byte_value,
	input  wire logic [TYPE_BITS-1:0] delim,
	output res_t                      res
);

	localparam int SIZE_BITS = SLOT_BITS * MAX_SIZE_BYTES;
	localparam int EXT_BITS  = SIZE_BITS + LENGTH_BITS;
	localparam int CNT_W     = $clog2(MAX_SIZE_BYTES + 1);
	localparam int SUM_BITS  = ((LENGTH_BITS + 1 > ACC_BITS) ? LENGTH_BITS + 1 : ACC_BITS) + 1;

	phase_t                 phase_q, phase_d;
	logic [SIZE_BITS-1:0]   size_q, size_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [LENGTH_BITS-1:0] left_q, left_d;
	logic [ACC_BITS-1:0]    acc_q, acc_d;
	logic                   seen_q, seen_d;
	logic                   halt_q, halt_d;

	logic [SIZE_BITS-1:0]   size_new;
	logic [EXT_BITS-1:0]    new_ext, old_ext;
	logic [CNT_W-1:0]       cnt_inc;
	logic                   cont, wide, too_small, trunc, is_delim, close_unit;
	logic [LENGTH_BITS-1:0] left_dec;
	logic [ACC_BITS-1:0]    base;
	logic [SUM_BITS-1:0]    sum;
	logic [ACC_BITS-1:0]    acc_add;

	always_comb begin
		size_new = size_q;
		for (int i = 0; i < MAX_SIZE_BYTES; i++) begin
			if (cnt_q == CNT_W'(i)) begin
				size_new[SLOT_BITS*i +: SLOT_BITS] = byte_value[SLOT_BITS-1:0];
			end
		end
	end

	assign new_ext    = {{LENGTH_BITS{1'b0}}, size_new};
	assign old_ext    = {{LENGTH_BITS{1'b0}}, size_q};
	assign cnt_inc    = cnt_q + CNT_W'(1);
	assign cont       = byte_value[BYTE_BITS-1];
	assign wide       = |new_ext[EXT_BITS-1:LENGTH_BITS];
	assign too_small  = size_new < SIZE_BITS'(HEADER_BYTES);
	assign trunc      = (phase_q == PH_HDR) || (phase_q == PH_BODY) || (cnt_q != '0);
	assign is_delim   = byte_value[TYPE_LSB +: TYPE_BITS] == delim;
	assign close_unit = is_delim && seen_q;
	assign left_dec   = left_q - LENGTH_BITS'(1);

	// restart the count at a closing delimiter, then add size plus field length
	assign base    = close_unit ? '0 : acc_q;
	assign sum     = SUM_BITS'(base) + SUM_BITS'(old_ext[LENGTH_BITS-1:0]) + SUM_BITS'(cnt_q);
	assign acc_add = (|sum[SUM_BITS-1:ACC_BITS]) ? {ACC_BITS{1'b1}} : sum[ACC_BITS-1:0];

	// next state
	always_comb begin
		phase_d = phase_q;
		size_d  = size_q;
		cnt_d   = cnt_q;
		left_d  = left_q;
		acc_d   = acc_q;
		seen_d  = seen_q;
		halt_d  = halt_q;
		if (action) begin
			phase_d = PH_SIZE;
			size_d  = '0;
			cnt_d   = '0;
			left_d  = '0;
			acc_d   = '0;
			seen_d  = 1'b0;
			halt_d  = 1'b0;
		end else if (!halt_q) begin
			unique case (phase_q)
				PH_HDR: begin
					if (is_delim) begin
						seen_d = 1'b1;
					end
					acc_d   = acc_add;
					left_d  = left_dec;
					phase_d = PH_BODY;
				end
				PH_BODY: begin
					if (left_q == '0 || left_q == LENGTH_BITS'(1)) begin
						left_d  = '0;
						phase_d = PH_SIZE;
						size_d  = '0;
						cnt_d   = '0;
					end else begin
						left_d = left_dec;
					end
				end
				default: begin
					phase_d = PH_SIZE;
					size_d  = size_new;
					cnt_d   = cnt_inc;
					if (cont) begin
						if (cnt_inc >= CNT_W'(MAX_SIZE_BYTES)) begin
							halt_d = 1'b1;
						end
					end else if (wide || too_small) begin
						halt_d = 1'b1;
					end else begin
						left_d  = new_ext[LENGTH_BITS-1:0];
						phase_d = PH_HDR;
					end
				end
			endcase
		end
	end

	// result of the presented word
	always_comb begin
		res.emit = 1'b0;
		res.len  = '0;
		res.err  = ERR_NONE;
		if (action) begin
			if (!halt_q) begin
				if (trunc) begin
					res.emit = 1'b1;
					res.err  = ERR_TRUNCATED;
				end else if (acc_q != '0) begin
					res.emit = 1'b1;
					res.len  = acc_q;
				end
			end
		end else if (!halt_q) begin
			unique case (phase_q)
				PH_HDR: begin
					if (close_unit) begin
						res.emit = 1'b1;
						res.len  = acc_q;
					end
				end
				PH_BODY: begin
					res.emit = 1'b0;
				end
				default: begin
					if (cont) begin
						if (cnt_inc >= CNT_W'(MAX_SIZE_BYTES)) begin
							res.emit = 1'b1;
							res.err  = ERR_FIELD_LONG;
						end
					end else if (wide) begin
						res.emit = 1'b1;
						res.err  = ERR_SIZE_WIDE;
					end else if (too_small) begin
						res.emit = 1'b1;
						res.err  = ERR_SIZE_SMALL;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			size_q  <= '0;
			cnt_q   <= '0;
			left_q  <= '0;
			acc_q   <= '0;
			seen_q  <= 1'b0;
			halt_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			size_q  <= size_d;
			cnt_q   <= cnt_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
			seen_q  <= seen_d;
			halt_q  <= halt_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/otus_checker.sv
//------------------------------------------------------------------------------
// otus_checker: port-level checks of the temporal unit splitter
// Watches the result channel for hold behavior and consistent result words.
//------------------------------------------------------------------------------
`default_nettype none

module otus_checker
	import otus_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     m_tvalid,
	input wire logic                     m_tready,
	input wire logic [OUT_DATA_BITS-1:0] m_tdata
);

	logic [ERR_BITS-1:0] err;
	logic [ACC_BITS-1:0] len;

	assign err = m_tdata[ERR_LSB +: ERR_BITS];
	assign len = m_tdata[ACC_BITS-1:0];

	// hold a stalled result word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (err == ERR_NONE || err == ERR_FIELD_LONG || err == ERR_SIZE_WIDE ||
			err == ERR_SIZE_SMALL || err == ERR_TRUNCATED))
		else $error("unknown error code");

	a_err_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && err != ERR_NONE |-> len == '0)
		else $error("error word carries a length");

	a_clean_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && err == ERR_NONE |-> len != '0)
		else $error("clean unit of zero length");

endmodule

bind obu_temporal_unit_splitter otus_checker u_otus_checker (.*);

`default_nettype wire

FILE: sim/tb_obu_temporal_unit_splitter.sv
//------------------------------------------------------------------------------
// tb_obu_temporal_unit_splitter: self-checking bench for the temporal unit splitter
// Feeds size-prefixed OBU streams byte by byte, tracks the parse state on the
// side and checks every emitted unit length and error code in order.
//------------------------------------------------------------------------------
`default_nettype none

module tb_obu_temporal_unit_splitter;
	import otus_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_WORDS = 1200;
	localparam logic [63:0] LEN_MAX = 64'hFFFF_FFFF;

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [BYTE_BITS-1:0]     s_tdata;   // [7:0] byte_value
	logic                     s_tuser;   // [0] action: 1 = end of stream
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata;   // [31:0] unit_length, [34:32] error_code
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [TYPE_BITS-1:0]     cfg_data;  // [4:0] delimiter_type_code

	obu_temporal_unit_splitter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// One unit the block still owes us: length and error code.
	typedef struct {
		logic [ACC_BITS-1:0] len;
		err_t                err;
	} unit_t;

	unit_t units_due[$];
	int    n_bad;
	int    n_words;
	int    n_cycles;
	bit    src_idle_on;
	bit    snk_idle_on;

	// Shadow parse state, updated at every accepted word.
	logic [TYPE_BITS-1:0] delim_code;
	phase_t               ps_phase;
	logic [63:0]          ps_size;
	int                   ps_field_bytes;
	logic [63:0]          ps_left;
	logic [63:0]          ps_acc;
	bit                   ps_seen_delim;
	bit                   ps_halted;

	function automatic void clear_stream_state();
		ps_phase       = PH_SIZE;
		ps_size        = '0;
		ps_field_bytes = 0;
		ps_left        = '0;
		ps_acc         = '0;
		ps_seen_delim  = 1'b0;
		ps_halted      = 1'b0;
	endfunction

	function automatic void queue_unit(input logic [63:0] len, input err_t err);
		unit_t u;
		u.len = len[ACC_BITS-1:0];
		u.err = err;
		units_due.push_back(u);
	endfunction

	function automatic void halt_with(input err_t err);
		ps_halted = 1'b1;
		queue_unit('0, err);
	endfunction

	// Advance the shadow state by one accepted word and queue any unit it closes.
	function automatic void predict_word(input bit eos, input logic [7:0] b);
		logic [TYPE_BITS-1:0] hdr_kind;
		logic [63:0]          add;
		if (eos) begin
			if (ps_halted) begin
				clear_stream_state();
			end else if (ps_phase != PH_SIZE || ps_field_bytes != 0) begin
				clear_stream_state();
				queue_unit('0, ERR_TRUNCATED);
			end else begin
				if (ps_acc != 0) queue_unit(ps_acc, ERR_NONE);
				clear_stream_state();
			end
			return;
		end
		if (ps_halted) return;
		case (ps_phase)
			PH_HDR: begin
				hdr_kind = b[TYPE_LSB +: TYPE_BITS];
				add = ps_size + 64'(ps_field_bytes);
				// a second delimiter closes the unit and starts the next one
				if (hdr_kind == delim_code && ps_seen_delim) begin
					queue_unit(ps_acc, ERR_NONE);
					ps_acc = '0;
				end
				if (hdr_kind == delim_code) ps_seen_delim = 1'b1;
				if (add > LEN_MAX - ps_acc) ps_acc = LEN_MAX;
				else ps_acc = ps_acc + add;
				ps_left  = ps_left - 1;
				ps_phase = PH_BODY;
			end
			PH_BODY: begin
				if (ps_left != 0) ps_left = ps_left - 1;
				if (ps_left == 0) begin
					ps_phase       = PH_SIZE;
					ps_size        = '0;
					ps_field_bytes = 0;
				end
			end
			default: begin
				ps_phase = PH_SIZE;
				if (ps_field_bytes < 8)
					ps_size = ps_size | (64'(b[SLOT_BITS-1:0]) << (SLOT_BITS * ps_field_bytes));
				ps_field_bytes++;
				if (b[7]) begin
					if (ps_field_bytes >= MAX_SIZE_BYTES_DEF) halt_with(ERR_FIELD_LONG);
				end else if (ps_size[63:LENGTH_BITS_DEF] != 0) begin
					halt_with(ERR_SIZE_WIDE);
				end else if (ps_size < HEADER_BYTES) begin
					halt_with(ERR_SIZE_SMALL);
				end else begin
					ps_left  = ps_size;
					ps_phase = PH_HDR;
				end
			end
		endcase
	endfunction

	// Offer one word after a random gap, hold it until taken, then predict.
	task automatic send_word(input bit eos, input logic [7:0] value);
		int gap;
		gap = src_idle_on ? $urandom_range(0, 18) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= eos;
		do @(posedge clk); while (!s_tready);
		predict_word(eos, value);
		n_words++;
	endtask

	task automatic send_eos();
		send_word(1'b1, 8'($urandom));
	endtask

	// LEB128 size, padded with continuation bytes up to field_len bytes.
	task automatic send_size_field(input logic [63:0] size, input int field_len);
		int n;
		n = field_len;
		while (n < 8 && (size >> (SLOT_BITS * n)) != 0) n++;
		for (int i = 0; i < n; i++)
			send_word(1'b0, {i < n - 1, 7'(size >> (SLOT_BITS * i))});
	endtask

	task automatic send_obu(input logic [TYPE_BITS-1:0] hdr_kind, input int payload,
			input int field_len);
		send_size_field(64'(payload + HEADER_BYTES), field_len);
		send_word(1'b0, {1'($urandom), hdr_kind, 2'($urandom)});
		for (int i = 0; i <= payload; i++) send_word(1'b0, 8'($urandom));
	endtask

	// Drop valid, wait for every owed unit, then let the pipeline drain.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (units_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_delim_code(input logic [TYPE_BITS-1:0] code);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= code;
		do @(posedge clk); while (!cfg_ready);
		delim_code = code;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sink side: wait a random number of cycles before taking each result.
	initial begin : sink
		int gap;
		wait (arst_n);
		forever begin
			@(negedge clk);
			gap = snk_idle_on ? $urandom_range(0, 18) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Compare each taken result with the oldest owed unit.
	always @(posedge clk) begin : check_units
		unit_t due;
		if (arst_n && m_tvalid && m_tready) begin
			if (units_due.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected unit: len %0d err %0d",
						m_tdata[ACC_BITS-1:0], m_tdata[ERR_LSB +: ERR_BITS]);
			end else begin
				due = units_due.pop_front();
				if (m_tdata[ACC_BITS-1:0] !== due.len ||
						m_tdata[ERR_LSB +: ERR_BITS] !== due.err) begin
					n_bad++;
					if (n_bad <= 10)
						$display("unit mismatch: expected len %0d err %0d, got len %0d err %0d",
							due.len, due.err, m_tdata[ACC_BITS-1:0],
							m_tdata[ERR_LSB +: ERR_BITS]);
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("tb_obu_temporal_unit_splitter NOT OK");
			$finish;
		end
	end

	// Reset register value: default delimiter type, units closed by delimiters
	// and by a clean end of stream, non-minimal size field, empty stream.
	task automatic test_units_after_reset();
		send_eos();
		send_word(1'b0, 8'h82);
		send_word(1'b0, 8'h00);
		send_word(1'b0, 8'h08);
		send_word(1'b0, 8'h00);
		send_obu(DELIM_RESET, 0, 1);
		send_word(1'b0, 8'h02);
		send_word(1'b0, 8'hFF);
		send_word(1'b0, 8'h00);
		send_obu(DELIM_RESET, 1, 1);
		send_eos();
	endtask

	// Every error path, saturation of the unit length and end of stream when halted.
	task automatic test_error_cases();
		// size field still continuing at its last allowed byte
		repeat (8) send_word(1'b0, 8'hFF);
		send_word(1'b0, 8'h05);
		send_eos();
		// size of exactly 2^32
		repeat (4) send_word(1'b0, 8'h80);
		send_word(1'b0, 8'h10);
		send_eos();
		// largest legal size saturates the length, then the stream is cut
		repeat (4) send_word(1'b0, 8'hFF);
		send_word(1'b0, 8'h0F);
		send_word(1'b0, 8'h08);
		send_eos();
		send_word(1'b0, 8'h00);
		send_eos();
		send_word(1'b0, 8'h01);
		send_eos();
		// cut inside a size field
		send_word(1'b0, 8'h80);
		send_eos();
	endtask

	task automatic send_stream();
		int n_obu;
		logic [TYPE_BITS-1:0] hdr_kind;
		n_obu = $urandom_range(1, 6);
		for (int k = 0; k < n_obu; k++) begin
			if ((k == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 3) == 0)
				hdr_kind = delim_code;
			else
				hdr_kind = 5'($urandom);
			send_obu(hdr_kind,
				($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 6),
				($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 1);
		end
		send_eos();
	endtask

	// A stream that goes wrong: cut inside an OBU, noise, or a bad or very large size field.
	task automatic send_broken_stream();
		int size;
		case ($urandom_range(0, 2))
			0: begin
				send_obu(delim_code, $urandom_range(0, 4), 1);
				size = $urandom_range(2, 12);
				send_size_field(64'(size), 1);
				repeat ($urandom_range(0, size - 1)) send_word(1'b0, 8'($urandom));
			end
			1: begin
				repeat ($urandom_range(1, 6)) send_word(1'b0, 8'($urandom));
			end
			default: begin
				case ($urandom_range(0, 2))
					0: send_word(1'b0, {7'b0, 1'($urandom)});
					1: repeat (8) send_word(1'b0, {1'b1, 7'($urandom)});
					default: begin
						repeat (4) send_word(1'b0, {1'b1, 7'($urandom)});
						send_word(1'b0, {1'b0, 3'($urandom), 4'($urandom_range(1, 15))});
					end
				endcase
				repeat ($urandom_range(0, 3)) send_word(1'b0, 8'($urandom));
			end
		endcase
		send_eos();
	endtask

	// Extreme and random delimiter codes, each followed by a few streams.
	task automatic test_delimiter_codes();
		logic [TYPE_BITS-1:0] codes[3];
		codes[0] = '0;
		codes[1] = '1;
		codes[2] = 5'($urandom);
		foreach (codes[i]) begin
			write_delim_code(codes[i]);
			repeat (3) send_stream();
		end
	endtask

	// Mostly well-formed streams with random content, some broken ones, and an
	// occasional register change; idling switches on and off per stream.
	task automatic test_random_streams();
		int stop_at;
		stop_at = n_words + RANDOM_WORDS;
		while (n_words < stop_at) begin
			src_idle_on = $urandom_range(0, 2) != 0;
			snk_idle_on = $urandom_range(0, 2) != 0;
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 2))
					0: write_delim_code('0);
					1: write_delim_code('1);
					default: write_delim_code(5'($urandom));
				endcase
			end
			if ($urandom_range(0, 7) == 0) send_broken_stream();
			else send_stream();
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = 1'b0;
		m_tready    = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		n_bad       = 0;
		n_words     = 0;
		n_cycles    = 0;
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		delim_code  = DELIM_RESET;
		clear_stream_state();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_units_after_reset();
		test_error_cases();
		test_delimiter_codes();
		test_random_streams();

		drain();
		repeat (6) @(posedge clk);
		n_bad = n_bad + units_due.size();
		if (n_bad == 0)
			$display("tb_obu_temporal_unit_splitter OK");
		else
			$display("tb_obu_temporal_unit_splitter NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
